// ===== src/fpba_pkg.sv =====
`default_nettype none

package fpba_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  // Fixed port widths
  localparam int SEL_W    = 4;
  localparam int VALUE_W  = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 8;
  localparam int POLICY_W = 2;
  localparam int COUNT_W  = 5;

  // Reset values of the configuration registers
  localparam logic [POLICY_W-1:0] POLICY_RST = 2'd0;
  localparam logic [COUNT_W-1:0]  COUNT_RST  = 5'd16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 4'd1;

  // Policy codes
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  // Item function codes
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

endpackage

`default_nettype wire

// ===== src/fit_policy_block_allocator_core.sv =====
`default_nettype none

// Block allocator with first, best and worst fit policies.
//
// Input channel: present func, block_sel and size_value with start; the beat
// is taken on a rising edge where start is high and busy is low. A load beat
// writes one block's size and clears its used mark. A request beat searches
// the table under the configured policy.
// Result channel: every item gives exactly one result beat, shown for one
// cycle with out_valid. The receiver cannot stall, so results never wait.
// A load, a request under the unused policy code and a request with a block
// count of zero answer in the cycle after acceptance with busy staying low.
// Any other request holds busy while it reads each block below lim (lim =
// block count, capped at NUM_BLOCKS) from the table memory, compares the
// last read data, passes the write-back step, and gives the registered result.
// The table memory has a single read port: it is read one entry per
// cycle.
// Configuration: cfg_valid/cfg_ready write policy_mode (index 0) and
// block_count (index 1); cfg_ready is always high. Write only while idle.
// Reset: synchronous, active low. Valid bits clear at once, so every block
// reads as size zero, not used; no clearing pass is needed.
module fit_policy_block_allocator_core #(
  parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_func,
  input  wire logic [fpba_pkg::SEL_W-1:0]      in_block_sel,
  input  wire logic [fpba_pkg::VALUE_W-1:0]    in_size_value,
  // result channel
  output logic                                 out_valid,
  output logic                                 out_granted,
  output logic [fpba_pkg::SEL_W-1:0]           out_chosen_block,
  // configuration channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int ENT_W = SIZE_BITS + 1;   // used mark on top of the size

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [fpba_pkg::POLICY_W-1:0] cfg_policy_r;
  logic [fpba_pkg::COUNT_W-1:0]  cfg_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_policy_r <= fpba_pkg::POLICY_RST;
      cfg_count_r  <= fpba_pkg::COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fpba_pkg::REG_POLICY_MODE: cfg_policy_r <= cfg_data[fpba_pkg::POLICY_W-1:0];
        fpba_pkg::REG_BLOCK_COUNT: cfg_count_r  <= cfg_data[fpba_pkg::COUNT_W-1:0];
        default: ;  // unknown index: drop the beat
      endcase
    end
  end

  // Search limit: block count capped at the table depth
  logic [CNT_W-1:0] lim;
  always_comb begin
    if (32'(cfg_count_r) > NUM_BLOCKS) begin
      lim = CNT_W'(NUM_BLOCKS);
    end else begin
      lim = CNT_W'(cfg_count_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  fpba_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]     rd_cnt_r;     // next block to read
  logic                 cmp_vld_r;    // read data returning this cycle
  logic [IDX_W-1:0]     cmp_idx_r;    // block index of the returning data
  logic [SIZE_BITS-1:0] req_r;        // requested size of the item at work
  logic                 found_r;
  logic [IDX_W-1:0]     pick_idx_r;
  logic [SIZE_BITS-1:0] pick_size_r;
  logic                 pick_used_r;

  logic                 accept;
  logic                 is_load;
  logic                 no_search;
  logic                 go_scan;
  logic                 rd_issue;
  logic                 wb_en;
  logic                 load_hit;

  assign accept    = start && !busy;
  assign is_load   = (in_func == fpba_pkg::FUNC_LOAD);
  assign no_search = (lim == '0) ||
                     !((cfg_policy_r == fpba_pkg::POL_FIRST) ||
                       (cfg_policy_r == fpba_pkg::POL_BEST)  ||
                       (cfg_policy_r == fpba_pkg::POL_WORST));
  assign load_hit  = accept && is_load && (32'(in_block_sel) < NUM_BLOCKS);

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b1;
    go_scan   = 1'b0;
    rd_issue  = 1'b0;
    wb_en     = 1'b0;
    unique case (state_r)
      fpba_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (accept && !is_load && !no_search) begin
          go_scan   = 1'b1;
          state_nxt = fpba_pkg::ST_SCAN;
        end
      end
      fpba_pkg::ST_SCAN: begin
        rd_issue = (rd_cnt_r < lim);
        // all reads issued and the last one compared in this cycle
        if (!rd_issue && cmp_vld_r) begin
          state_nxt = fpba_pkg::ST_WRITE;
        end
      end
      fpba_pkg::ST_WRITE: begin
        wb_en     = found_r;
        state_nxt = fpba_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = fpba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpba_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Table memory: {used mark, size} per block, with a valid bit per entry so
  // that an entry never written since reset reads as all zero.
  // ---------------------------------------------------------------------------
  logic [ENT_W-1:0]      mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] ent_vld_r;
  logic [ENT_W-1:0]      mem_q_r;
  logic                  rd_vld_r;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [ENT_W-1:0]      wr_data;
  logic [IDX_W-1:0]      rd_addr;

  assign rd_addr = rd_cnt_r[IDX_W-1:0];

  always_comb begin
    wr_en   = load_hit || wb_en;
    wr_addr = pick_idx_r;
    wr_data = {1'b1, pick_size_r};
    if (load_hit) begin
      // load: new size, used mark cleared
      wr_addr = IDX_W'(in_block_sel);
      wr_data = {1'b0, SIZE_BITS'(in_size_value)};
    end else if (cfg_policy_r == fpba_pkg::POL_BEST) begin
      // best fit: shrink the block, keep its used mark
      wr_data = {pick_used_r, pick_size_r - req_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_issue) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_issue) begin
        rd_vld_r <= ent_vld_r[rd_addr];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Compare stage
  // ---------------------------------------------------------------------------
  logic [SIZE_BITS-1:0] ent_size;
  logic                 ent_used;
  logic                 fits;
  logic                 cand;

  assign ent_size = rd_vld_r ? mem_q_r[SIZE_BITS-1:0] : '0;
  assign ent_used = rd_vld_r ? mem_q_r[SIZE_BITS] : 1'b0;
  assign fits     = (req_r <= ent_size);

  always_comb begin
    unique case (cfg_policy_r)
      fpba_pkg::POL_FIRST: cand = !ent_used && fits && !found_r;
      fpba_pkg::POL_BEST:  cand = fits && (!found_r || ent_size <= pick_size_r);
      fpba_pkg::POL_WORST: cand = !ent_used && fits && (!found_r || ent_size >= pick_size_r);
      default:             cand = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r  <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else if (go_scan) begin
      // start a new search from block zero
      rd_cnt_r  <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      cmp_vld_r <= rd_issue;
      if (rd_issue) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
      if (cmp_vld_r && cand) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go_scan) begin
      req_r <= SIZE_BITS'(in_size_value);
    end
    if (rd_issue) begin
      cmp_idx_r <= rd_addr;
    end
    if (cmp_vld_r && cand) begin
      pick_idx_r  <= cmp_idx_r;
      pick_size_r <= ent_size;
      pick_used_r <= ent_used;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: one beat per item
  // ---------------------------------------------------------------------------
  logic                       out_valid_r;
  logic                       out_granted_r;
  logic [fpba_pkg::SEL_W-1:0] out_chosen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (accept && (is_load || no_search)) ||
                     (state_r == fpba_pkg::ST_WRITE);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == fpba_pkg::ST_WRITE) begin
      out_granted_r <= found_r;
      out_chosen_r  <= found_r ? fpba_pkg::SEL_W'(pick_idx_r) : '0;
    end else begin
      out_granted_r <= 1'b0;
      out_chosen_r  <= '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted      = out_granted_r;
  assign out_chosen_block = out_chosen_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither answered nor in progress");

  a_write_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fpba_pkg::ST_WRITE) |=> (out_valid && !busy))
    else $error("write-back not followed by a result beat");

  a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_granted) |-> (32'(out_chosen_block) < NUM_BLOCKS))
    else $error("granted block outside the table");

  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fpba_pkg::ST_SCAN) |-> (rd_cnt_r <= lim))
    else $error("scan ran past the search limit");

endmodule

`default_nettype wire
